// ===== rtl/core/vnp_pkg.sv =====
// ----------------------------------------------------------------------------
// vnp_pkg
// Shared widths, mode codes and pipeline tag type of the vector normalizer.
// ----------------------------------------------------------------------------
package vnp_pkg;

   localparam int COMP_W = 32;
   localparam int FRAC_W = 16;
   localparam int SQ_W   = 64;
   localparam int SUM_W  = 65;
   localparam int ROOT_W = 33;
   localparam int NUM_W  = 49;
   localparam int LANES  = 4;

   localparam logic [1:0] MODE_NORM4 = 2'd0;
   localparam logic [1:0] MODE_NORM3 = 2'd1;
   localparam logic [1:0] MODE_DIV   = 2'd2;

   localparam logic [COMP_W-1:0] ONE_Q     = 32'h0001_0000;
   localparam logic [COMP_W-1:0] W_EPS_RAW = 32'd6;

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      comp_type [LANES-1:0] comp;
      logic [1:0]           mode;
      logic [ROOT_W-1:0]    mag;
      logic                 degen;
   } vnp_tag_type;

endpackage

// ===== rtl/core/vnp_sqrt.sv =====
// ----------------------------------------------------------------------------
// vnp_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vnp_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [vnp_pkg::SUM_W-1:0]   in_rad,
   input  vnp_pkg::vnp_tag_type        in_tag,
   output logic                        out_valid,
   output logic [vnp_pkg::ROOT_W-1:0]  out_root,
   output vnp_pkg::vnp_tag_type        out_tag
);
   import vnp_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic              v_ff    [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_in  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   vnp_tag_type       tag_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              src_v;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      vnp_tag_type       src_tag;
      logic [REM_W-1:0]  shifted;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_rad  = {1'b0, in_rad};
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_tag  = in_tag;
      end else begin : g_next
         assign src_v    = v_ff[k-1];
         assign src_rad  = rad_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_tag  = tag_ff[k-1];
      end

      assign shifted    = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
      assign trial      = {1'b0, src_root, 2'b01};
      assign ge         = shifted >= trial;
      assign rem_in[k]  = ge ? shifted - trial : shifted;
      assign root_in[k] = {src_root[ROOT_W-2:0], ge};
      assign rad_in[k]  = {src_rad[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            tag_ff[k]  <= src_tag;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

// ===== rtl/core/vnp_div.sv =====
// ----------------------------------------------------------------------------
// vnp_div
// Pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module vnp_div (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  logic [vnp_pkg::LANES-1:0][vnp_pkg::NUM_W-1:0] in_num,
   input  logic [vnp_pkg::ROOT_W-1:0]                    in_den,
   input  vnp_pkg::vnp_tag_type                          in_tag,
   output logic                                          out_valid,
   output logic [vnp_pkg::LANES-1:0][vnp_pkg::NUM_W-1:0] out_quo,
   output vnp_pkg::vnp_tag_type                          out_tag
);
   import vnp_pkg::*;

   typedef logic [LANES-1:0][NUM_W-1:0]  numq_type;
   typedef logic [LANES-1:0][ROOT_W-1:0] rem_type;

   logic              v_ff    [NUM_W];
   numq_type          numq_ff [NUM_W];
   numq_type          numq_in [NUM_W];
   rem_type           rem_ff  [NUM_W];
   rem_type           rem_in  [NUM_W];
   logic [ROOT_W-1:0] den_ff  [NUM_W];
   vnp_tag_type       tag_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              src_v;
      numq_type          src_numq;
      rem_type           src_rem;
      logic [ROOT_W-1:0] src_den;
      vnp_tag_type       src_tag;

      if (k == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_numq = in_num;
         assign src_rem  = '0;
         assign src_den  = in_den;
         assign src_tag  = in_tag;
      end else begin : g_next
         assign src_v    = v_ff[k-1];
         assign src_numq = numq_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_tag  = tag_ff[k-1];
      end

      for (genvar j = 0; j < LANES; j++) begin : g_lane
         logic [ROOT_W:0] sh;
         logic [ROOT_W:0] diff;
         logic            ge;

         assign sh   = {src_rem[j], src_numq[j][NUM_W-1]};
         assign diff = sh - {1'b0, src_den};
         assign ge   = sh >= {1'b0, src_den};
         assign rem_in[k][j]  = ge ? diff[ROOT_W-1:0] : sh[ROOT_W-1:0];
         assign numq_in[k][j] = {src_numq[j][NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            numq_ff[k] <= numq_in[k];
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= src_den;
            tag_ff[k]  <= src_tag;
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = numq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

// ===== rtl/core/vector_normalize_project.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_project
// The pipeline runs through input, square, sum, 33 root stages, divisor setup,
// 49 divider stages and the output register. Throughput is one item per
// cycle; the whole pipeline holds while a result waits under stall.
// Reset clears all valid bits and sets the mode register to zero.
// Normalizes a Q16.16 vector in four or three dimensions, or divides by w.
// ----------------------------------------------------------------------------
module vector_normalize_project #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_vec_x,
   input  logic signed [31:0]            req_vec_y,
   input  logic signed [31:0]            req_vec_z,
   input  logic signed [31:0]            req_vec_w,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_out_z,
   output logic signed [31:0]            rsp_out_w,
   output logic [32:0]                   rsp_magnitude,
   output logic                          rsp_degenerate,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_wdata
);
   import vnp_pkg::*;

   localparam int CW_EFF = (COMPONENT_WIDTH < COMP_W) ? COMPONENT_WIDTH : COMP_W;
   localparam int SH     = COMP_W - CW_EFF;
   localparam int ST_W   = NUM_W + 1;
   localparam logic signed [ST_W-1:0] SAT_HI = ST_W'((64'sd1 <<< (CW_EFF - 1)) - 64'sd1);
   localparam logic signed [ST_W-1:0] SAT_LO = -SAT_HI - ST_W'(1);

   function automatic comp_type sext_in(input logic [COMP_W-1:0] v);
      logic [COMP_W-1:0] up;
      up = v << SH;
      return $signed(up) >>> SH;
   endfunction

   function automatic logic [COMP_W-1:0] abs_of(input comp_type v);
      return v[COMP_W-1] ? COMP_W'(0) - v : v;
   endfunction

   function automatic comp_type sat_comp(input logic signed [ST_W-1:0] v);
      logic signed [ST_W-1:0] c;
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      return COMP_W'(c);
   endfunction

   logic        en;
   logic [1:0]  mode_ff;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORM4;
      end else if (csr_write) begin
         mode_ff <= csr_wdata;
      end
   end

   // Input stage.
   logic        s1_v_ff;
   vnp_tag_type s1_tag_ff;
   vnp_tag_type s1_tag_in;

   always_comb begin
      s1_tag_in         = '0;
      s1_tag_in.comp[0] = sext_in(req_vec_x);
      s1_tag_in.comp[1] = sext_in(req_vec_y);
      s1_tag_in.comp[2] = sext_in(req_vec_z);
      s1_tag_in.comp[3] = sext_in(req_vec_w);
      s1_tag_in.mode    = mode_ff;
   end

   // Square stage.
   logic                  s2_v_ff;
   vnp_tag_type           s2_tag_ff;
   logic [LANES-1:0][SQ_W-1:0] s2_sq_ff;
   logic [LANES-1:0][SQ_W-1:0] s2_sq_in;

   for (genvar j = 0; j < LANES; j++) begin : g_sq
      logic [COMP_W-1:0] a;
      assign a           = abs_of(s1_tag_ff.comp[j]);
      assign s2_sq_in[j] = SQ_W'(a) * SQ_W'(a);
   end

   // Sum stage.
   logic             s3_v_ff;
   vnp_tag_type      s3_tag_ff;
   logic [SUM_W-1:0] s3_sum_ff;
   logic [SUM_W-1:0] s3_sum_in;

   assign s3_sum_in = SUM_W'(s2_sq_ff[0]) + SUM_W'(s2_sq_ff[1]) + SUM_W'(s2_sq_ff[2])
                    + ((s2_tag_ff.mode == MODE_NORM4) ? SUM_W'(s2_sq_ff[3]) : SUM_W'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
         s2_sq_ff  <= s2_sq_in;
         s3_tag_ff <= s2_tag_ff;
         s3_sum_ff <= s3_sum_in;
      end
   end

   logic              rt_v;
   logic [ROOT_W-1:0] rt_root;
   vnp_tag_type       rt_tag;

   vnp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .in_rad    (s3_sum_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (rt_v),
      .out_root  (rt_root),
      .out_tag   (rt_tag)
   );

   // Divisor setup stage.
   logic                         su_norm;
   logic [COMP_W-1:0]            su_wabs;
   logic [ROOT_W-1:0]            su_den;
   vnp_tag_type                  su_tag;
   logic [LANES-1:0][NUM_W-1:0]  su_num;
   logic                         s4_v_ff;
   vnp_tag_type                  s4_tag_ff;
   logic [ROOT_W-1:0]            s4_den_ff;
   logic [LANES-1:0][NUM_W-1:0]  s4_num_ff;

   always_comb begin
      su_norm   = (rt_tag.mode == MODE_NORM4) || (rt_tag.mode == MODE_NORM3);
      su_wabs   = abs_of(rt_tag.comp[3]);
      su_tag    = rt_tag;
      su_tag.degen = su_norm ? (rt_root == '0) : (su_wabs <= W_EPS_RAW);
      su_tag.mag   = (su_norm && !su_tag.degen) ? rt_root : '0;
      if (su_tag.degen) begin
         su_den = ROOT_W'(1);
      end else if (su_norm) begin
         su_den = rt_root;
      end else begin
         su_den = {1'b0, su_wabs};
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_num
      assign su_num[j] = {1'b0, abs_of(rt_tag.comp[j]), {FRAC_W{1'b0}}}
                       + NUM_W'(su_den[ROOT_W-1:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= rt_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_tag_ff <= su_tag;
         s4_den_ff <= su_den;
         s4_num_ff <= su_num;
      end
   end

   logic                        dv_v;
   logic [LANES-1:0][NUM_W-1:0] dv_quo;
   vnp_tag_type                 dv_tag;

   vnp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   // Sign, saturation and result selection.
   comp_type [LANES-1:0] lane_res;
   comp_type [LANES-1:0] res;
   comp_type             one_sat;
   logic                 fin_div;

   assign fin_div = !((dv_tag.mode == MODE_NORM4) || (dv_tag.mode == MODE_NORM3));
   assign one_sat = sat_comp(ST_W'(ONE_Q));

   for (genvar j = 0; j < LANES; j++) begin : g_fin
      logic                   neg;
      logic signed [ST_W-1:0] q;
      assign neg = dv_tag.comp[j][COMP_W-1] ^ (fin_div & dv_tag.comp[3][COMP_W-1]);
      assign q   = $signed({1'b0, dv_quo[j]});
      assign lane_res[j] = sat_comp(neg ? -q : q);
   end

   always_comb begin
      res = lane_res;
      unique case (dv_tag.mode)
         MODE_NORM4: begin
            if (dv_tag.degen) res = '0;
         end
         MODE_NORM3: begin
            if (dv_tag.degen) begin
               res    = '0;
               res[3] = one_sat;
            end else begin
               res[3] = dv_tag.comp[3];
            end
         end
         default: begin
            if (dv_tag.degen) begin
               res = dv_tag.comp;
            end else begin
               res[3] = one_sat;
            end
         end
      endcase
   end

   logic        out_v_ff;
   comp_type    out_x_ff, out_y_ff, out_z_ff, out_w_ff;
   logic [32:0] out_mag_ff;
   logic        out_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff   <= res[0];
         out_y_ff   <= res[1];
         out_z_ff   <= res[2];
         out_w_ff   <= res[3];
         out_mag_ff <= dv_tag.mag;
         out_deg_ff <= dv_tag.degen;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_out_z      = out_z_ff;
   assign rsp_out_w      = out_w_ff;
   assign rsp_magnitude  = out_mag_ff;
   assign rsp_degenerate = out_deg_ff;

endmodule
